/* hdl/lsc_pkg.sv */
`default_nettype none
package lsc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_X_MIN = 2'd0,
      REG_X_MAX = 2'd1,
      REG_Y_MIN = 2'd2,
      REG_Y_MAX = 2'd3
   } reg_index_type;

   localparam int RESET_MIN = -60;
   localparam int RESET_MAX = 60;

   // status carried from the front end to the back end with each segment
   typedef struct packed {
      logic valid;
      logic keep;
   } seg_status_type;

endpackage
`default_nettype wire

/* hdl/lsc_divider.sv */
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
// Computes min((|q| << FRAC) / |p|, 2 << FRAC) and applies sign.
module lsc_divider
   import lsc_pkg::*;
#(
   parameter int DW   = 17,
   parameter int FRAC = 16,
   parameter int TW   = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              stall,
   input  wire  [DW-1:0]    num_mag,
   input  wire  [DW-1:0]    den_mag,
   input  wire              neg,
   input  wire  [TW-1:0]    tag_in,
   output logic [FRAC+2:0]  quot,
   output logic [TW-1:0]    tag_out
);
   // quotient width: up to (2^DW << FRAC) / 1, saturated after
   localparam int NW = DW + FRAC;
   localparam int ST = NW;

   logic [NW-1:0]   num_ff   [ST+1];
   logic [NW-1:0]   rem_ff   [ST+1];
   logic [NW-1:0]   q_ff     [ST+1];
   logic [DW-1:0]   den_ff   [ST+1];
   logic            neg_ff   [ST+1];
   logic [TW-1:0]   tag_ff   [ST+1];

   always_ff @(posedge clock) begin
      if (!stall) begin
         num_ff[0] <= {num_mag, {FRAC{1'b0}}};
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= neg;
      end
      if (reset) tag_ff[0] <= '0;
      else if (!stall) tag_ff[0] <= tag_in;
   end

   // one quotient bit per stage, msb first
   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic [NW:0] trial_in;
      logic [NW:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[s], num_ff[s][NW-1]};
         diff_in  = trial_in - {{(NW+1-DW){1'b0}}, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (!stall) begin
            num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b0};
            if (!diff_in[NW]) begin
               rem_ff[s+1] <= diff_in[NW-1:0];
               q_ff[s+1]   <= {q_ff[s][NW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial_in[NW-1:0];
               q_ff[s+1]   <= {q_ff[s][NW-2:0], 1'b0};
            end
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
         if (reset) tag_ff[s+1] <= '0;
         else if (!stall) tag_ff[s+1] <= tag_ff[s];
      end
   end

   // saturate to 2.0 and apply sign
   logic [FRAC+2:0] sat_mag;
   localparam logic [NW-1:0] SAT_NW = NW'(2) << FRAC;
   always_comb begin
      if (q_ff[ST] > SAT_NW) sat_mag = (FRAC+3)'(2) << FRAC;
      else                   sat_mag = q_ff[ST][FRAC+2:0];
      quot    = neg_ff[ST] ? (~sat_mag + 1'b1) : sat_mag;
      tag_out = tag_ff[ST];
   end
endmodule
`default_nettype wire

/* hdl/lsc_front.sv */
`default_nettype none
// Front end: form p and q per edge, divide, and pick entry/exit bounds.
module lsc_front
   import lsc_pkg::*;
#(
   parameter int CW   = COORD_WIDTH_DEF,
   parameter int FRAC = FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     stall,
   input  wire                     in_valid,
   input  wire  signed [CW-1:0]    x1,
   input  wire  signed [CW-1:0]    y1,
   input  wire  signed [CW-1:0]    x2,
   input  wire  signed [CW-1:0]    y2,
   input  wire  signed [CW-1:0]    xmin,
   input  wire  signed [CW-1:0]    xmax,
   input  wire  signed [CW-1:0]    ymin,
   input  wire  signed [CW-1:0]    ymax,
   output seg_status_type          st_out,
   output logic signed [CW-1:0]    o_x1,
   output logic signed [CW-1:0]    o_y1,
   output logic signed [CW:0]      o_dx,
   output logic signed [CW:0]      o_dy,
   output logic signed [FRAC+2:0]  o_uin,
   output logic signed [FRAC+2:0]  o_uout
);
   localparam int DW = CW + 1;
   localparam int RW = FRAC + 3;
   // tag: valid, reject, x1, y1, dx, dy, zero flags and p-sign per edge
   localparam int TW = 2 + 2*CW + 2*DW + 8;

   logic signed [DW-1:0] dx, dy;
   logic signed [DW-1:0] p [4];
   logic signed [DW-1:0] q [4];
   logic                 rej;
   logic [3:0]           pz, pn;
   logic [TW-1:0]        tag_in;
   logic [TW-1:0]        tag_o [4];
   logic [RW-1:0]        r [4];

   always_comb begin
      dx = DW'(x2) - DW'(x1);
      dy = DW'(y2) - DW'(y1);
      p[0] = -dx; q[0] = DW'(x1) - DW'(xmin);
      p[1] = dx;  q[1] = DW'(xmax) - DW'(x1);
      p[2] = -dy; q[2] = DW'(y1) - DW'(ymin);
      p[3] = dy;  q[3] = DW'(ymax) - DW'(y1);
      rej = 1'b0;
      for (int i = 0; i < 4; i++) begin
         pz[i] = (p[i] == '0);
         pn[i] = p[i][DW-1];
         if (pz[i] && q[i][DW-1]) rej = 1'b1;
      end
      tag_in = {in_valid, rej, x1, y1, dx, dy, pz, pn};
   end

   // four dividers in parallel, one per edge
   for (genvar e = 0; e < 4; e++) begin : g_div
      logic [DW-1:0] qm, pm;
      always_comb begin
         qm = q[e][DW-1] ? DW'(-q[e]) : q[e];
         pm = p[e][DW-1] ? DW'(-p[e]) : p[e];
      end
      lsc_divider #(.DW(DW), .FRAC(FRAC), .TW(TW)) u_div (
         .clock(clock), .reset(reset), .stall(stall),
         .num_mag(qm), .den_mag(pm), .neg(q[e][DW-1] ^ p[e][DW-1]),
         .tag_in(tag_in), .quot(r[e]), .tag_out(tag_o[e])
      );
   end

   // fold ratios into entry and exit bounds
   logic [3:0] t_pz, t_pn;
   logic signed [RW-1:0] uin, uout, rv;
   logic rej_t;
   always_comb begin
      {st_out.valid, rej_t, o_x1, o_y1, o_dx, o_dy, t_pz, t_pn} = tag_o[0];
      uin  = '0;
      uout = RW'(1) << FRAC;
      for (int i = 0; i < 4; i++) begin
         rv = r[i];
         if (!t_pz[i]) begin
            if (t_pn[i]) begin
               if (rv > uin) uin = rv;
            end else if (rv < uout) uout = rv;
         end
      end
      st_out.keep = !rej_t && !(uin > uout);
      o_uin  = uin;
      o_uout = uout;
   end

   logic unused_tags;
   assign unused_tags = ^{tag_o[1], tag_o[2], tag_o[3]};
endmodule
`default_nettype wire

/* hdl/lsc_back.sv */
`default_nettype none
// Back end: scale u*d with rounding and form the clipped endpoints.
module lsc_back
   import lsc_pkg::*;
#(
   parameter int CW   = COORD_WIDTH_DEF,
   parameter int FRAC = FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     stall,
   input  seg_status_type          st_in,
   input  wire  signed [CW-1:0]    x1,
   input  wire  signed [CW-1:0]    y1,
   input  wire  signed [CW:0]      dx,
   input  wire  signed [CW:0]      dy,
   input  wire  signed [FRAC+2:0]  uin,
   input  wire  signed [FRAC+2:0]  uout,
   output logic                    out_valid,
   output logic [4*CW:0]           out_data
);
   localparam int DW = CW + 1;
   localparam int RW = FRAC + 3;
   localparam int PW = DW + RW;

   // stage 1: signed products
   logic signed [PW-1:0] prod_ff [4];
   logic signed [CW-1:0] x1_ff, y1_ff;
   logic                 v1_ff, k1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (!stall) v1_ff <= st_in.valid;
      if (!stall) begin
         k1_ff      <= st_in.keep;
         x1_ff      <= x1;
         y1_ff      <= y1;
         prod_ff[0] <= PW'(uin) * PW'(dx);
         prod_ff[1] <= PW'(uin) * PW'(dy);
         prod_ff[2] <= PW'(uout) * PW'(dx);
         prod_ff[3] <= PW'(uout) * PW'(dy);
      end
   end

   // stage 2: round half away from zero and add base
   logic [CW-1:0] res [4];
   always_comb begin
      logic [PW-1:0] m;
      logic [PW-1:0] rm;
      logic signed [CW-1:0] base;
      for (int i = 0; i < 4; i++) begin
         m    = prod_ff[i][PW-1] ? PW'(-prod_ff[i]) : prod_ff[i];
         rm   = (m + (PW'(1) << (FRAC-1))) >> FRAC;
         if (prod_ff[i][PW-1]) rm = PW'(-rm);
         base = (i % 2 == 0) ? x1_ff : y1_ff;
         res[i] = k1_ff ? CW'(base + CW'(rm)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (!stall) out_valid <= v1_ff;
      if (!stall) out_data <= {res[3], res[2], res[1], res[0], k1_ff};
   end
endmodule
`default_nettype wire

/* hdl/line_segment_clipper.sv */
`default_nettype none
// Liang-Barsky segment clipper.
// req_ channel: one segment per transfer, tdata = {end_y,end_x,start_y,start_x}.
// rsp_ channel: one result per segment, tdata = {clip_end_y,clip_end_x,
//   clip_start_y,clip_start_x,visible} padded to whole bytes.
// csr_ port: APB write/read of the four window registers at 4*i.
// rsp_tvalid rises once the req_ transfer has passed the bit-per-stage
// pipelined dividers in the front end, the back end's product and output
// registers, and the queue's registered read.
// Throughput: one segment per cycle while req_tready is high.
// A result queue of QDEPTH entries sits behind the pipeline; the input is
// taken only while the queue has room for every segment still in flight, so
// a stalled receiver fills the queue and then stops req_tready.
// Reset empties the pipeline and queue and loads window -60..60.
module line_segment_clipper
   import lsc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, end_x, end_y from bit 0
   input  wire  [4*COORD_WIDTH-1:0]         req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y from bit 0
   output logic [((4*COORD_WIDTH+8)/8)*8-1:0] rsp_tdata,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [3:0]                       csr_paddr,
   input  wire  [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   localparam int CW  = COORD_WIDTH;
   localparam int OW  = 4*CW + 1;
   localparam int TDW = ((4*CW + 8)/8)*8;
   localparam int DEPTH = CW + 1 + FRAC_BITS + 3;
   localparam int QDEPTH = 64;
   localparam int QAW = $clog2(QDEPTH);

   // window registers
   logic signed [CW-1:0] win_ff [4];
   reg_index_type        widx;
   assign csr_pready = 1'b1;
   assign widx = reg_index_type'(csr_paddr[3:2]);
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[REG_X_MIN] <= CW'(RESET_MIN);
         win_ff[REG_X_MAX] <= CW'(RESET_MAX);
         win_ff[REG_Y_MIN] <= CW'(RESET_MIN);
         win_ff[REG_Y_MAX] <= CW'(RESET_MAX);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         win_ff[widx] <= csr_pwdata[CW-1:0];
      end
   end
   // sign-extend the selected register
   always_comb begin
      csr_prdata = 32'(win_ff[widx]);
   end

   // credit count: segments in flight plus queued
   logic [QAW:0] used_ff, used_in;
   logic         take, give;
   assign req_tready = (used_ff < (QAW+1)'(QDEPTH));
   assign take = req_tvalid && req_tready;
   assign give = rsp_tvalid && rsp_tready;
   always_comb used_in = used_ff + (QAW+1)'(take) - (QAW+1)'(give);
   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else       used_ff <= used_in;
   end

   // pipeline never stalls: credits reserve queue space
   seg_status_type               st;
   logic signed [CW-1:0]         fx1, fy1;
   logic signed [CW:0]           fdx, fdy;
   logic signed [FRAC_BITS+2:0]  uin, uout;
   logic                         pv;
   logic [OW-1:0]                pdata;

   lsc_front #(.CW(CW), .FRAC(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .stall(1'b0), .in_valid(take),
      .x1(req_tdata[CW-1:0]), .y1(req_tdata[2*CW-1:CW]),
      .x2(req_tdata[3*CW-1:2*CW]), .y2(req_tdata[4*CW-1:3*CW]),
      .xmin(win_ff[REG_X_MIN]), .xmax(win_ff[REG_X_MAX]),
      .ymin(win_ff[REG_Y_MIN]), .ymax(win_ff[REG_Y_MAX]),
      .st_out(st), .o_x1(fx1), .o_y1(fy1), .o_dx(fdx), .o_dy(fdy),
      .o_uin(uin), .o_uout(uout)
   );

   lsc_back #(.CW(CW), .FRAC(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .stall(1'b0), .st_in(st),
      .x1(fx1), .y1(fy1), .dx(fdx), .dy(fdy), .uin(uin), .uout(uout),
      .out_valid(pv), .out_data(pdata)
   );

   // result queue with registered read
   logic [OW-1:0]  mem [QDEPTH];
   logic [QAW:0]   wp_ff, rp_ff;
   logic [OW-1:0]  rd_ff;
   logic           rv_ff;
   logic           pop;
   assign pop = (wp_ff != rp_ff) && (!rv_ff || rsp_tready);
   always_ff @(posedge clock) begin
      if (pv) mem[wp_ff[QAW-1:0]] <= pdata;
      if (pop) rd_ff <= mem[rp_ff[QAW-1:0]];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (pv) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         if (pop) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = TDW'(rd_ff);

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= (QAW+1)'(QDEPTH)) else $error("result queue overflow");
   // credits cover every occupied slot
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= used_ff) else $error("credit count below occupancy");
   // rejected results carry zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rd_ff[0]) |-> (rd_ff[OW-1:1] == '0)) else $error("reject not zero");

   logic unused;
   assign unused = ^{csr_pwdata[31:CW], DEPTH};
endmodule
`default_nettype wire
